>>> sv/mtg_pkg.sv
package mtg_pkg;

   // Generator dimensions.
   localparam int unsigned STATE_WORDS  = 624;
   localparam int unsigned TWIST_OFFSET = 397;
   localparam int unsigned WORD_W       = 32;
   localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);

   // Index arithmetic on the state ring.
   localparam logic [ADDR_W-1:0] LAST_INDEX   = ADDR_W'(STATE_WORDS - 1);
   localparam logic [ADDR_W-1:0] FAR_FORWARD  = ADDR_W'(TWIST_OFFSET);
   localparam logic [ADDR_W-1:0] FAR_BACKWARD = ADDR_W'(STATE_WORDS - TWIST_OFFSET);

   // Recurrence and twist constants.
   localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
   localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

   // Tempering masks.
   localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc6_0000;

   // Request kinds carried on the request tuser bit.
   localparam logic REQ_DRAW   = 1'b0;
   localparam logic REQ_RESEED = 1'b1;

endpackage

>>> sv/mtg_temper.sv
module mtg_temper
   import mtg_pkg::*;
(
   input  logic [WORD_W-1:0] raw_word,
   output logic [WORD_W-1:0] tempered_word
);

   logic [WORD_W-1:0] stage1;
   logic [WORD_W-1:0] stage2;
   logic [WORD_W-1:0] stage3;

   // Four shift-and-xor tempering steps.
   always_comb begin
      stage1        = raw_word ^ (raw_word >> 11);
      stage2        = stage1 ^ ((stage1 << 7) & TEMPER_B);
      stage3        = stage2 ^ ((stage2 << 15) & TEMPER_C);
      tempered_word = stage3 ^ (stage3 >> 18);
   end

endmodule

>>> sv/mersenne_twister_generator_core.sv
// MT19937 32-bit pseudo-random word generator.
// Requests arrive on the req_ channel. req_tuser selects the kind: a draw
// returns one tempered word on the rsp_ channel, a reseed loads req_tdata as
// the new seed and returns nothing. The csr_ channel writes the default seed,
// which is used when a draw arrives before any reseed.
// The 624-word state lives in one synchronous RAM. A draw twists only the
// word it consumes: three reads (current, next, far word), one calculation
// and one write-back; the request channel stays busy until the write-back.
// Seeding writes one word per cycle through the multiply-add recurrence, so
// a reseed keeps the request channel busy until every state word is written.
// A draw on an unseeded generator first runs that seeding pass from the
// default seed and then twists and returns the first word of the new state.
// Reset marks the generator unseeded and restores the default seed to 5489;
// the RAM contents are not cleared.
// A finished result is held in the response register; the next request is
// still accepted, and a draw waits at its write-back step until the
// receiver has taken the previous result.
module mersenne_twister_generator_core
   import mtg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Request channel.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] seed_value
   input  logic              req_tuser,   // [0] req_type
   // Response channel.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] random_word
   // Default seed write channel.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEED   = 6'b000010,
      ST_RD_CUR = 6'b000100,
      ST_RD_NXT = 6'b001000,
      ST_RD_FAR = 6'b010000,
      ST_CALC   = 6'b100000
   } state_type;

   // The write-back step shares the calculation result; it is its own state.
   typedef enum logic [1:0] {
      WB_NONE = 2'b01,
      WB_WAIT = 2'b10
   } wb_type;

   state_type           state_ff, state_in;
   wb_type              wb_ff, wb_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic                seeded_ff, seeded_in;
   logic                draw_pend_ff, draw_pend_in;
   logic [WORD_W-1:0]   default_seed_ff;
   logic [WORD_W-1:0]   prev_ff, prev_in;
   logic                upper_ff, upper_in;
   logic [WORD_W-2:0]   lower_ff, lower_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                rsp_tvalid_ff;
   logic [WORD_W-1:0]   rsp_tdata_ff;

   logic [WORD_W-1:0]   state_mem [STATE_WORDS];
   logic [WORD_W-1:0]   rd_data_ff;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [WORD_W-1:0]   wr_data;

   logic                req_accept;
   logic                rsp_load;
   logic [ADDR_W-1:0]   nxt_addr;
   logic [ADDR_W-1:0]   far_addr;
   logic [ADDR_W-1:0]   pos_wrap;
   logic [ADDR_W-1:0]   cnt_plus1;
   logic [WORD_W-1:0]   seed_mix;
   logic [WORD_W-1:0]   seed_prod;
   logic [WORD_W-1:0]   tempered;

   assign req_tready = (state_ff == ST_IDLE) && (wb_ff == WB_NONE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Ring neighbors of the word being drawn.
   assign pos_wrap = (pos_ff == LAST_INDEX) ? '0 : pos_ff + 1'b1;
   assign nxt_addr = pos_wrap;
   assign far_addr = (pos_ff < FAR_BACKWARD) ? pos_ff + FAR_FORWARD
                                             : pos_ff - FAR_BACKWARD;

   // Seeding recurrence: one multiply-add per state word.
   assign cnt_plus1 = cnt_ff + 1'b1;
   assign seed_mix  = prev_ff ^ (prev_ff >> 30);
   assign seed_prod = seed_mix * SEED_MULT;

   mtg_temper u_temper (
      .raw_word      (word_ff),
      .tempered_word (tempered)
   );

   // The response register is free when empty or being taken.
   assign rsp_load = (wb_ff == WB_WAIT) && (!rsp_tvalid_ff || rsp_tready);

   // Sequencer and RAM port control.
   always_comb begin
      state_in     = state_ff;
      wb_in        = wb_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      seeded_in    = seeded_ff;
      draw_pend_in = draw_pend_ff;
      prev_in      = prev_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      word_in      = word_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = prev_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == REQ_RESEED) begin
                  prev_in      = req_tdata;
                  cnt_in       = '0;
                  draw_pend_in = 1'b0;
                  state_in     = ST_SEED;
               end else if (!seeded_ff) begin
                  prev_in      = default_seed_ff;
                  cnt_in       = '0;
                  draw_pend_in = 1'b1;
                  state_in     = ST_SEED;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = pos_ff;
                  state_in = ST_RD_NXT;
               end
            end
         end
         ST_SEED: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = prev_ff;
            prev_in = seed_prod + WORD_W'(cnt_plus1);
            cnt_in  = cnt_plus1;
            if (cnt_ff == LAST_INDEX) begin
               seeded_in = 1'b1;
               pos_in    = '0;
               state_in  = draw_pend_ff ? ST_RD_CUR : ST_IDLE;
            end
         end
         ST_RD_CUR: begin
            draw_pend_in = 1'b0;
            rd_en        = 1'b1;
            rd_addr      = pos_ff;
            state_in     = ST_RD_NXT;
         end
         ST_RD_NXT: begin
            upper_in = rd_data_ff[WORD_W-1];
            rd_en    = 1'b1;
            rd_addr  = nxt_addr;
            state_in = ST_RD_FAR;
         end
         ST_RD_FAR: begin
            lower_in = rd_data_ff[WORD_W-2:0];
            rd_en    = 1'b1;
            rd_addr  = far_addr;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            word_in  = rd_data_ff ^ {1'b0, upper_ff, lower_ff[WORD_W-2:1]}
                       ^ (lower_ff[0] ? TWIST_MATRIX : '0);
            wb_in    = WB_WAIT;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write-back of the twisted word once the response register is free.
      if (rsp_load) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff;
         wr_data = word_ff;
         pos_in  = pos_wrap;
         wb_in   = WB_NONE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         wb_ff           <= WB_NONE;
         pos_ff          <= '0;
         cnt_ff          <= '0;
         seeded_ff       <= 1'b0;
         draw_pend_ff    <= 1'b0;
         default_seed_ff <= DEFAULT_SEED;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wb_ff        <= wb_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         seeded_ff    <= seeded_in;
         draw_pend_ff <= draw_pend_in;
         if (csr_valid && csr_ready) begin
            default_seed_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      prev_ff  <= prev_in;
      upper_ff <= upper_in;
      lower_ff <= lower_in;
      word_ff  <= word_in;
      if (rsp_load) begin
         rsp_tdata_ff <= tempered;
      end
   end

   // State RAM with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= state_mem[rd_addr];
      end
   end

`ifndef NO_ASSERTIONS
   // The sequencer never reads and writes the same entry in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("state RAM read and write collide");

   // The draw position stays on the ring.
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_INDEX)
      else $error("draw position out of range");

   // Completing a seeding pass marks the state seeded at position zero.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED && cnt_ff == LAST_INDEX) |=> (seeded_ff && pos_ff == '0))
      else $error("seeding pass did not finish cleanly");

   // A twist only ever reads a seeded state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_NXT) |-> seeded_ff)
      else $error("draw started on unseeded state");

   // A result is only loaded after the calculation step of a draw.
   assert property (@(posedge clock) disable iff (reset)
      $rose(wb_ff == WB_WAIT) |-> $past(state_ff == ST_CALC))
      else $error("write-back without a calculated word");
`endif

endmodule

>>> tb/tb_twister_pkg.sv
package tb_twister_pkg;
   import mtg_pkg::*;

   // Predicts the tempered words of the generator and checks them in arrival order.
   class twister_prediction;
      logic [WORD_W-1:0] state_words [STATE_WORDS];
      int unsigned       word_index;
      logic [WORD_W-1:0] fallback_seed;
      logic [WORD_W-1:0] pending_words [$];
      int unsigned       failures;

      function new();
         foreach (state_words[i]) state_words[i] = '0;
         word_index    = STATE_WORDS + 1;
         fallback_seed = DEFAULT_SEED;
         failures      = 0;
      endfunction

      function void set_default_seed(input logic [WORD_W-1:0] value);
         fallback_seed = value;
      endfunction

      // Fill the state from a seed with the multiply-add recurrence.
      function void load_seed(input logic [WORD_W-1:0] seed);
         logic [WORD_W-1:0] prev;
         prev           = seed;
         state_words[0] = seed;
         for (int unsigned i = 1; i < STATE_WORDS; i++) begin
            prev           = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
            state_words[i] = prev;
         end
         word_index = STATE_WORDS;
      endfunction

      // Regenerate the whole state in place.
      function void regenerate();
         logic [WORD_W-1:0] mixed;
         int unsigned       nxt;
         int unsigned       far_word;
         for (int unsigned k = 0; k < STATE_WORDS; k++) begin
            nxt            = (k + 1) % STATE_WORDS;
            far_word       = (k + TWIST_OFFSET) % STATE_WORDS;
            mixed          = {state_words[k][WORD_W-1], state_words[nxt][WORD_W-2:0]};
            state_words[k] = state_words[far_word] ^ (mixed >> 1) ^
                             (mixed[0] ? TWIST_MATRIX : '0);
         end
         word_index = 0;
      endfunction

      function logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] w);
         logic [WORD_W-1:0] y;
         y = w;
         y = y ^ (y >> 11);
         y = y ^ ((y << 7) & TEMPER_B);
         y = y ^ ((y << 15) & TEMPER_C);
         y = y ^ (y >> 18);
         return y;
      endfunction

      // Called for every accepted request transaction.
      function void accept_request(input logic kind, input logic [WORD_W-1:0] seed);
         if (kind == REQ_RESEED) begin
            load_seed(seed);
         end else begin
            if (word_index >= STATE_WORDS) begin
               if (word_index != STATE_WORDS) load_seed(fallback_seed);
               regenerate();
            end
            pending_words.push_back(tempered(state_words[word_index]));
            word_index++;
         end
      endfunction

      function void report(input string what);
         failures++;
         if (failures <= 10) $display("%s", what);
      endfunction

      // Called for every accepted response transaction.
      function void check_word(input logic [WORD_W-1:0] actual);
         logic [WORD_W-1:0] expected_word;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected word %08h with no draw outstanding", actual));
         end else begin
            expected_word = pending_words.pop_front();
            if (actual !== expected_word)
               report($sformatf("random_word mismatch: expected %08h, got %08h",
                                expected_word, actual));
         end
      endfunction

      function int unsigned outstanding();
         return pending_words.size();
      endfunction

      function void close_out();
         if (pending_words.size() != 0) begin
            $display("%0d draw results never arrived", pending_words.size());
            failures += pending_words.size();
         end
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mtg_pkg::*;
   import tb_twister_pkg::*;

   localparam int unsigned SETTLE_CYCLES  = 700;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned HOLD_AT_WORD   = 50;
   localparam int unsigned QUIET_LIMIT    = 5000;
   localparam int unsigned DRAW_RUN       = 630;
   localparam int unsigned MIXED_RUN      = 70;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = REQ_DRAW;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data   = '0;

   twister_prediction predictor = new();
   int unsigned       requests_sent  = 0;
   int unsigned       words_received = 0;
   int unsigned       quiet_cycles   = 0;

   mersenne_twister_generator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offer one request; tvalid stays high when no gap is drawn.
   task automatic send_request(input logic kind, input logic [31:0] seed);
      int unsigned gap;
      gap = (requests_sent % 100 < 30) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= seed;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      predictor.accept_request(kind, seed);
      requests_sent++;
   endtask

   // Write the default seed; the caller lowers csr_valid after the last write.
   task automatic write_default_seed(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      predictor.set_default_seed(value);
   endtask

   // Wait for every expected word, then let a reseed pass finish.
   task automatic drain;
      while (predictor.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Main stimulus.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Both extremes of the default seed; the first draw seeds from the last one.
      write_default_seed(32'h0000_0000);
      write_default_seed(32'hffff_ffff);
      csr_valid <= 1'b0;

      // Directed requests: an unseeded draw, extreme seeds, back-to-back reseeds.
      send_request(REQ_DRAW,   32'h0000_0000);
      send_request(REQ_DRAW,   32'hffff_ffff);
      send_request(REQ_DRAW,   $urandom);
      send_request(REQ_RESEED, 32'h0000_0000);
      send_request(REQ_DRAW,   $urandom);
      send_request(REQ_DRAW,   $urandom);
      send_request(REQ_RESEED, 32'hffff_ffff);
      send_request(REQ_RESEED, 32'd5489);
      send_request(REQ_DRAW,   32'h0000_0000);
      send_request(REQ_DRAW,   32'hffff_ffff);
      send_request(REQ_DRAW,   $urandom);
      send_request(REQ_RESEED, $urandom);
      send_request(REQ_DRAW,   $urandom);
      send_request(REQ_RESEED, 32'h8000_0001);
      send_request(REQ_DRAW,   $urandom);
      req_tvalid <= 1'b0;
      drain();

      // Register changes once seeded must have no effect.
      write_default_seed($urandom);
      write_default_seed(DEFAULT_SEED);
      csr_valid <= 1'b0;

      // A long run of draws that wraps past the end of the state.
      for (int unsigned n = 0; n < DRAW_RUN; n++) send_request(REQ_DRAW, $urandom);
      req_tvalid <= 1'b0;
      drain();

      write_default_seed(32'h0000_0000);
      csr_valid <= 1'b0;

      // Draws mixed with random reseeds.
      for (int unsigned n = 0; n < MIXED_RUN; n++) begin
         if ($urandom_range(0, 5) == 0) send_request(REQ_RESEED, $urandom);
         else                           send_request(REQ_DRAW, $urandom);
      end
      req_tvalid <= 1'b0;
      drain();

      predictor.close_out();
      if (predictor.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Receiver: random stalls, bursts with none, and one long hold-off.
   initial begin
      int unsigned gap;
      do @(posedge clock); while (reset);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            predictor.check_word(rsp_tdata);
            words_received++;
            gap = (words_received % 90 < 25) ? 0 : $urandom_range(0, 12);
            if (words_received == HOLD_AT_WORD) gap = HOLD_CYCLES;
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Watchdog on stretches with no transaction on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
